>>> rtl/core/lifn_pkg.sv
// ----------------------------------------------------------------------------
// lifn_pkg
// Shared types, constants and saturating Q16.16 helpers of the neuron array.
// ----------------------------------------------------------------------------
package lifn_pkg;

    localparam int NEURONS_DEFAULT = 1024;
    localparam int NEURON_W        = 10;
    localparam int DATA_W          = 32;
    localparam int RATE_W          = 17;
    localparam int CFG_INDEX_W     = 3;
    localparam int PROD_W          = DATA_W + RATE_W + 1;
    localparam int STAGES          = 7;

    localparam logic [RATE_W-1:0] RATE_ONE = 17'd65536;

    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_STEP = 1'b1;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_THRESHOLD     = 3'd0,
        CFG_RESET_VOLTAGE = 3'd1,
        CFG_LEAK_RATE     = 3'd2,
        CFG_HARD_RESET    = 3'd3,
        CFG_DECAY_INPUT   = 3'd4
    } t_cfg_index;

    typedef struct packed {
        logic signed [DATA_W-1:0] threshold;
        logic signed [DATA_W-1:0] reset_voltage;
        logic        [RATE_W-1:0] leak_rate;
        logic                     hard_reset;
        logic                     decay_input;
    } t_cfg;

    typedef struct packed {
        logic                       kind;
        logic                       ok;
        logic        [NEURON_W-1:0] neuron;
        logic signed [DATA_W-1:0]   x;
        logic signed [DATA_W-1:0]   v;
        logic signed [DATA_W-1:0]   w;
    } t_item;

    function automatic logic signed [DATA_W-1:0] sat33(input logic signed [DATA_W:0] s);
        logic signed [DATA_W-1:0] r;
        if (s[DATA_W] != s[DATA_W-1]) begin
            r = s[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
        end else begin
            r = s[DATA_W-1:0];
        end
        return r;
    endfunction

    function automatic logic signed [DATA_W-1:0] sat_add(input logic signed [DATA_W-1:0] a,
                                                         input logic signed [DATA_W-1:0] b);
        logic signed [DATA_W:0] s;
        s = {a[DATA_W-1], a} + {b[DATA_W-1], b};
        return sat33(s);
    endfunction

    function automatic logic signed [DATA_W-1:0] sat_sub(input logic signed [DATA_W-1:0] a,
                                                         input logic signed [DATA_W-1:0] b);
        logic signed [DATA_W:0] s;
        s = {a[DATA_W-1], a} - {b[DATA_W-1], b};
        return sat33(s);
    endfunction

    // Rounds a Q16.16 by Q1.16 product back to Q16.16, half toward plus infinity.
    function automatic logic signed [DATA_W-1:0] round_q16(input logic signed [PROD_W-1:0] p);
        logic signed [PROD_W-1:0] s;
        logic        [PROD_W-17:0] q;
        logic signed [DATA_W-1:0] r;
        s = p + PROD_W'(32768);
        q = s[PROD_W-1:16];
        if ((q[PROD_W-17:DATA_W-1] == '0) || (q[PROD_W-17:DATA_W-1] == '1)) begin
            r = q[DATA_W-1:0];
        end else begin
            r = q[PROD_W-17] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
        end
        return r;
    endfunction

endpackage

>>> rtl/core/lifn_cfg.sv
// ----------------------------------------------------------------------------
// lifn_cfg
// Configuration registers of the neuron array, written one beat at a time.
// ----------------------------------------------------------------------------
module lifn_cfg (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [lifn_pkg::CFG_INDEX_W-1:0]     i_cfg_index,
    input  logic [lifn_pkg::DATA_W-1:0]          i_cfg_data,
    output lifn_pkg::t_cfg                       o_cfg
);
    import lifn_pkg::*;

    t_cfg              r_cfg;
    logic [RATE_W-1:0] w_rate;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;
    assign w_rate      = (i_cfg_data[RATE_W-1:0] > RATE_ONE) ? RATE_ONE
                                                             : i_cfg_data[RATE_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.threshold     <= 32'sd65536;
            r_cfg.reset_voltage <= '0;
            r_cfg.leak_rate     <= 17'd32768;
            r_cfg.hard_reset    <= 1'b1;
            r_cfg.decay_input   <= 1'b1;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_THRESHOLD:     r_cfg.threshold     <= i_cfg_data;
                CFG_RESET_VOLTAGE: r_cfg.reset_voltage <= i_cfg_data;
                CFG_LEAK_RATE:     r_cfg.leak_rate     <= w_rate;
                CFG_HARD_RESET:    r_cfg.hard_reset    <= i_cfg_data[0];
                CFG_DECAY_INPUT:   r_cfg.decay_input   <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

endmodule

>>> rtl/core/lifn_mem.sv
// ----------------------------------------------------------------------------
// lifn_mem
// Membrane voltage memory: one write port and one registered read port.
// ----------------------------------------------------------------------------
module lifn_mem #(
    parameter int NEURONS = lifn_pkg::NEURONS_DEFAULT,
    parameter int AW      = (NEURONS > 1) ? $clog2(NEURONS) : 1
) (
    input  logic                          i_clk,
    input  logic                          i_rd_en,
    input  logic [AW-1:0]                 i_rd_addr,
    output logic [lifn_pkg::DATA_W-1:0]   o_rd_data,
    input  logic                          i_wr_en,
    input  logic [AW-1:0]                 i_wr_addr,
    input  logic [lifn_pkg::DATA_W-1:0]   i_wr_data
);
    import lifn_pkg::*;

    logic [DATA_W-1:0] r_mem [NEURONS];
    logic [DATA_W-1:0] r_rd_data;

    assign o_rd_data = r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

>>> rtl/core/lifn_pipe.sv
// ----------------------------------------------------------------------------
// lifn_pipe
// Read-modify-write pipeline: charges, fires and resets one neuron per beat.
// ----------------------------------------------------------------------------
module lifn_pipe #(
    parameter int NEURONS = lifn_pkg::NEURONS_DEFAULT,
    parameter int AW      = (NEURONS > 1) ? $clog2(NEURONS) : 1
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  lifn_pkg::t_cfg                       i_cfg,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic                                 i_kind,
    input  logic [lifn_pkg::NEURON_W-1:0]        i_neuron,
    input  logic signed [lifn_pkg::DATA_W-1:0]   i_value,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic signed [lifn_pkg::DATA_W-1:0]   o_charged,
    output logic                                 o_spike,
    output logic signed [lifn_pkg::DATA_W-1:0]   o_voltage,
    output logic                                 o_rd_en,
    output logic [AW-1:0]                        o_rd_addr,
    input  logic [lifn_pkg::DATA_W-1:0]          i_rd_data,
    output logic                                 o_wr_en,
    output logic [AW-1:0]                        o_wr_addr,
    output logic [lifn_pkg::DATA_W-1:0]          o_wr_data
);
    import lifn_pkg::*;

    localparam int EXT_W = 17;

    t_item                     r_st   [1:STAGES];
    logic                      r_vld  [1:STAGES];
    t_item                     n_st   [1:STAGES];
    logic                      w_take [1:STAGES+1];
    logic signed [PROD_W-1:0]  r_prod;
    logic signed [PROD_W-1:0]  n_prod;
    logic                      r_out_valid;
    logic                      r_out_kind;
    logic signed [DATA_W-1:0]  r_charged;
    logic                      r_spike;
    logic signed [DATA_W-1:0]  r_voltage;
    logic                      w_hazard;
    logic                      w_accept;
    logic                      w_fire;
    logic signed [DATA_W-1:0]  w_next;
    logic [EXT_W-1:0]          w_in_ext;
    logic [EXT_W-1:0]          w_wr_ext;

    always_comb begin
        w_take[STAGES+1] = !r_out_valid || i_out_ready;
        for (int k = STAGES; k >= 1; k--) begin
            w_take[k] = !r_vld[k] || w_take[k+1];
        end
    end

    // A step must not read a neuron that an older beat has yet to write back.
    always_comb begin
        w_hazard = 1'b0;
        for (int k = 1; k <= STAGES; k++) begin
            if (r_vld[k] && (r_st[k].neuron == i_neuron)) begin
                w_hazard = 1'b1;
            end
        end
        w_hazard = w_hazard && (i_kind == KIND_STEP);
    end

    assign o_in_ready = w_take[1] && !w_hazard;
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_in_ext   = {{(EXT_W-NEURON_W){1'b0}}, i_neuron};
    assign o_rd_en    = w_accept;
    assign o_rd_addr  = w_in_ext[AW-1:0];

    always_comb begin
        n_st[1]        = r_st[1];
        n_st[1].kind   = i_kind;
        n_st[1].ok     = w_in_ext < EXT_W'(NEURONS);
        n_st[1].neuron = i_neuron;
        n_st[1].x      = i_value;

        n_st[2]   = r_st[1];
        n_st[2].v = r_st[1].ok ? i_rd_data : '0;
        n_st[2].w = sat_sub(n_st[2].v, i_cfg.reset_voltage);

        n_st[3]   = r_st[2];
        n_st[3].w = i_cfg.decay_input ? sat_sub(r_st[2].x, r_st[2].w) : r_st[2].w;

        n_st[4] = r_st[3];
        n_prod  = $signed(r_st[3].w) * $signed({1'b0, i_cfg.leak_rate});

        n_st[5]   = r_st[4];
        n_st[5].w = round_q16(r_prod);

        n_st[6]   = r_st[5];
        n_st[6].w = i_cfg.decay_input ? sat_add(r_st[5].v, r_st[5].w)
                                      : sat_sub(r_st[5].v, r_st[5].w);

        n_st[7] = r_st[6];
        if (r_st[6].kind == KIND_LOAD) begin
            n_st[7].w = r_st[6].x;
        end else if (!i_cfg.decay_input) begin
            n_st[7].w = sat_add(r_st[6].w, r_st[6].x);
        end
    end

    always_comb begin
        w_fire = (r_st[STAGES].kind == KIND_STEP)
              && ($signed(r_st[STAGES].w) >= $signed(i_cfg.threshold));
        if (!w_fire) begin
            w_next = r_st[STAGES].w;
        end else if (i_cfg.hard_reset) begin
            w_next = i_cfg.reset_voltage;
        end else begin
            w_next = sat_sub(r_st[STAGES].w, i_cfg.threshold);
        end
    end

    assign w_wr_ext  = {{(EXT_W-NEURON_W){1'b0}}, r_st[STAGES].neuron};
    assign o_wr_en   = r_vld[STAGES] && w_take[STAGES+1] && r_st[STAGES].ok;
    assign o_wr_addr = w_wr_ext[AW-1:0];
    assign o_wr_data = w_next;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 1; k <= STAGES; k++) begin
                r_vld[k] <= 1'b0;
            end
            r_out_valid <= 1'b0;
        end else begin
            if (w_take[1]) begin
                r_vld[1] <= w_accept;
            end
            for (int k = 2; k <= STAGES; k++) begin
                if (w_take[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
            if (w_take[STAGES+1]) begin
                r_out_valid <= r_vld[STAGES];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take[1]) begin
            r_st[1] <= n_st[1];
        end
        for (int k = 2; k <= STAGES; k++) begin
            if (w_take[k]) begin
                r_st[k] <= n_st[k];
            end
        end
        if (w_take[4]) begin
            r_prod <= n_prod;
        end
        if (w_take[STAGES+1]) begin
            r_out_kind <= r_st[STAGES].kind;
            r_charged  <= r_st[STAGES].w;
            r_spike    <= w_fire;
            r_voltage  <= w_next;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_charged   = r_charged;
    assign o_spike     = r_spike;
    assign o_voltage   = r_voltage;

`ifndef SYNTHESIS
    a_no_read_of_pending_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_kind == KIND_STEP)) |-> !(r_vld[STAGES]
            && (r_st[STAGES].neuron == i_neuron)))
        else $error("Step read a neuron with a write-back still pending.");

    a_stalled_tail_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[STAGES] && !w_take[STAGES+1]) |=> (r_vld[STAGES] && $stable(r_st[STAGES])))
        else $error("Last stage changed while the output was stalled.");

    a_load_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_kind == KIND_LOAD)) |-> (!r_spike && (r_charged == r_voltage)))
        else $error("Load beat produced a spike or a changed voltage.");

    a_hard_reset_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_spike && i_cfg.hard_reset) |-> (r_voltage == i_cfg.reset_voltage))
        else $error("Hard reset did not restore the reset voltage.");
`endif

endmodule

>>> rtl/core/lif_neuron_array_step.sv
// ----------------------------------------------------------------------------
// lif_neuron_array_step
// Array of leaky integrate-and-fire neurons with Q16.16 membrane voltages.
// ----------------------------------------------------------------------------
// Each beat either loads one neuron's voltage or charges it with an input
// current, fires against the threshold and, on a spike, stores the reset
// voltage or subtracts the threshold. The block takes one beat per cycle
// unless the output stalls or a step waits on a write-back, and returns each
// result from an output register behind seven pipeline stages. The voltages
// sit in a single memory with one write and one registered read port, and a
// beat is written back as it leaves the last stage, so a step beat on a neuron
// still held in those stages waits for that write-back. The memory is not
// cleared after reset, so every neuron must be loaded before its first step.
// Configuration writes are taken at once and must be made only while idle.
module lif_neuron_array_step #(
    parameter int NEURONS = lifn_pkg::NEURONS_DEFAULT
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [lifn_pkg::CFG_INDEX_W-1:0]     i_cfg_index,
    input  logic [lifn_pkg::DATA_W-1:0]          i_cfg_data,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic                                 i_kind,
    input  logic [lifn_pkg::NEURON_W-1:0]        i_neuron,
    input  logic signed [lifn_pkg::DATA_W-1:0]   i_value,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic signed [lifn_pkg::DATA_W-1:0]   o_charged,
    output logic                                 o_spike,
    output logic signed [lifn_pkg::DATA_W-1:0]   o_voltage
);
    import lifn_pkg::*;

    localparam int AW = (NEURONS > 1) ? $clog2(NEURONS) : 1;

    t_cfg              w_cfg;
    logic              w_rd_en;
    logic [AW-1:0]     w_rd_addr;
    logic [DATA_W-1:0] w_rd_data;
    logic              w_wr_en;
    logic [AW-1:0]     w_wr_addr;
    logic [DATA_W-1:0] w_wr_data;

    lifn_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    lifn_mem #(
        .NEURONS (NEURONS),
        .AW      (AW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data)
    );

    lifn_pipe #(
        .NEURONS (NEURONS),
        .AW      (AW)
    ) u_pipe (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_kind      (i_kind),
        .i_neuron    (i_neuron),
        .i_value     (i_value),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_charged   (o_charged),
        .o_spike     (o_spike),
        .o_voltage   (o_voltage),
        .o_rd_en     (w_rd_en),
        .o_rd_addr   (w_rd_addr),
        .i_rd_data   (w_rd_data),
        .o_wr_en     (w_wr_en),
        .o_wr_addr   (w_wr_addr),
        .o_wr_data   (w_wr_data)
    );

endmodule
